[design/roberts_cross_edge_core_defines.svh]
// Assertion macros used by the checker file of the Roberts cross edge core.
`ifndef ROBERTS_CROSS_EDGE_CORE_DEFINES_SVH
`define ROBERTS_CROSS_EDGE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, held off while i_rst_n is low.
`define RCE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("roberts_cross_edge_core check failed");

// Next-cycle implication, sampled on i_clk, held off while i_rst_n is low.
`define RCE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("roberts_cross_edge_core check failed");

// Next-cycle implication that is also checked across reset.
`define RCE_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("roberts_cross_edge_core check failed");

`endif

[design/rce_pkg.sv]
// Types and constants of the Roberts cross edge core.
`default_nettype none
package rce_pkg;

    localparam int PIX_W   = 8;
    localparam int POS_W   = 12;
    localparam int CFG_W   = 13;
    localparam int OUT_W   = 2 * POS_W + PIX_W;
    localparam int ROOT_W  = 9;
    localparam int RAD_W   = 2 * ROOT_W;
    localparam int REM_W   = 12;

    localparam logic [3:0] ROOT_LAST_STEP = 4'd8;

    localparam logic [CFG_W-1:0] CFG_MIN    = 13'd2;
    localparam logic [CFG_W-1:0] HEIGHT_MAX = 13'd4096;
    localparam logic [POS_W-1:0] HLAST_RST  = 12'd479;
    localparam int               WIDTH_RST  = 640;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_ROOT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] value;
    } t_result;

endpackage
`default_nettype wire

[design/roberts_cross_edge_core.sv]
// Roberts cross edge core: line store, 2x2 window, iterative root and result sequencer.
//
//  channel   | direction | handshake                      | payload
//  s_axis    | in        | s_axis_tvalid / s_axis_tready  | tdata[7:0] pixel
//  m_axis    | out       | m_axis_tvalid / m_axis_tready  | tdata row, col, value; tlast
//  cfg       | in        | i_cfg_we                       | i_cfg_index, i_cfg_data
//
// A pixel passes one line store read and nine steps of the bit-serial square root; then its
// results leave one a cycle when m_axis does not stall, and only then is the next pixel taken.
// The line store has one write and one read port.
// Synchronous active-low reset clears the control state; the line store is not cleared.
// A stall on m_axis holds the sequencer in its emit step; the output register
// keeps the last result while the next pixel is taken.
`default_nettype none
module roberts_cross_edge_core #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            s_axis_tvalid,
    output logic                           s_axis_tready,
    input  wire  [7:0]                     s_axis_tdata,   // [7:0] pixel
    output logic                           m_axis_tvalid,
    input  wire                            m_axis_tready,
    output logic [rce_pkg::OUT_W-1:0]      m_axis_tdata,   // [11:0] out_row, [23:12] out_col,
                                                           // [31:24] edge_value
    output logic                           m_axis_tlast,
    input  wire                            i_cfg_we,
    input  wire                            i_cfg_index,
    input  wire  [rce_pkg::CFG_W-1:0]      i_cfg_data
);
    import rce_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int WL_RST = ((WIDTH_RST < MAX_WIDTH) ? WIDTH_RST : MAX_WIDTH) - 1;

    t_state r_state, n_state;

    logic [CW-1:0]    r_wlast;
    logic [POS_W-1:0] r_hlast;
    logic [CW-1:0]    r_col;
    logic [POS_W-1:0] r_row;

    logic [CW-1:0]    r_icol;
    logic [POS_W-1:0] r_irow;
    logic [PIX_W-1:0] r_px;
    logic [PIX_W-1:0] r_top;
    logic [PIX_W-1:0] r_left_cur;
    logic [PIX_W-1:0] r_left_prev;

    logic [PIX_W-1:0] r_line [MAX_WIDTH];
    logic [PIX_W-1:0] r_rd;

    logic [RAD_W-1:0]  r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [3:0]        r_step;

    logic [2:0]    r_pend;
    logic          r_mvalid;
    t_result       r_mdata;
    logic          r_mlast;

    logic accept, mem_we, push, root_done;
    logic [CW-1:0]    cfg_wlast;
    logic [POS_W-1:0] cfg_hlast;

    logic [PIX_W-1:0]   ad1, ad2;
    logic [2*PIX_W-1:0] sq1, sq2;
    logic [RAD_W-2:0]   sum;
    logic [REM_W-1:0]   rem_sh, trial;

    logic [2:0]  sel;
    t_result     res0, res1, res2, res_sel;
    logic [PIX_W-1:0] sat;

    assign accept    = s_axis_tvalid && s_axis_tready;
    assign root_done = (r_step == ROOT_LAST_STEP);

    always_comb begin
        if (i_cfg_data < CFG_MIN) begin
            cfg_wlast = CW'(1);
        end else if (32'(i_cfg_data) > MAX_WIDTH) begin
            cfg_wlast = CW'(MAX_WIDTH - 1);
        end else begin
            cfg_wlast = CW'(i_cfg_data - 13'd1);
        end
        if (i_cfg_data < CFG_MIN) begin
            cfg_hlast = 12'd1;
        end else if (i_cfg_data > HEIGHT_MAX) begin
            cfg_hlast = 12'd4095;
        end else begin
            cfg_hlast = 12'(i_cfg_data - 13'd1);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_READ;
            end
            S_READ: begin
                n_state = S_ROOT;
            end
            S_ROOT: begin
                if (root_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_pend == 3'b000) begin
                    n_state = S_IDLE;
                end else if (push && ((r_pend & ~sel) == 3'b000)) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        mem_we        = 1'b0;
        push          = 1'b0;
        case (r_state)
            S_IDLE: s_axis_tready = !i_cfg_we;
            S_READ: mem_we = 1'b1;
            S_ROOT: ;
            S_EMIT: push = (r_pend != 3'b000) && (!r_mvalid || m_axis_tready);
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Size registers and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast <= CW'(WL_RST);
            r_hlast <= HLAST_RST;
            r_col   <= '0;
            r_row   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WIDTH) begin
                r_wlast <= cfg_wlast;
            end else begin
                r_hlast <= cfg_hlast;
            end
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            if (r_col == r_wlast) begin
                r_col <= '0;
                r_row <= (r_row == r_hlast) ? '0 : r_row + 12'd1;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_line[r_icol] <= r_px;
        r_rd <= r_line[r_col];
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px   <= s_axis_tdata;
            r_icol <= r_col;
            r_irow <= r_row;
        end
    end

    always_comb begin
        ad1 = (r_left_prev > r_px) ? r_left_prev - r_px : r_px - r_left_prev;
        ad2 = (r_left_cur > r_rd) ? r_left_cur - r_rd : r_rd - r_left_cur;
        sq1 = ad1 * ad1;
        sq2 = ad2 * ad2;
        sum = {1'b0, sq1} + {1'b0, sq2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_cur  <= '0;
            r_left_prev <= '0;
        end else if (r_state == S_READ) begin
            r_left_cur  <= r_px;
            r_left_prev <= r_rd;
        end
    end

    always_comb begin
        rem_sh = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
        trial  = {1'b0, r_root, 2'b01};
    end

    // Restoring square root, two radicand bits a step
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_top  <= r_rd;
            r_rad  <= {1'b0, sum};
            r_rem  <= '0;
            r_root <= '0;
            r_step <= '0;
        end else if (r_state == S_ROOT) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_step <= r_step + 4'd1;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else if (r_state == S_READ) begin
            r_pend[0] <= (r_irow != '0) && (r_icol != '0);
            r_pend[1] <= (r_irow != '0) && (r_icol == r_wlast);
            r_pend[2] <= (r_irow == r_hlast);
        end else if (push) begin
            r_pend <= r_pend & ~sel;
        end
    end

    always_comb begin
        sat = r_root[ROOT_W-1] ? 8'hFF : r_root[PIX_W-1:0];
        res0.row   = r_irow - 12'd1;
        res0.col   = 12'(r_icol - CW'(1));
        res0.value = sat;
        res1.row   = r_irow - 12'd1;
        res1.col   = 12'(r_icol);
        res1.value = r_top;
        res2.row   = r_irow;
        res2.col   = 12'(r_icol);
        res2.value = r_px;
        sel     = r_pend & (~r_pend + 3'd1);
        res_sel = sel[0] ? res0 : (sel[1] ? res1 : res2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvalid <= 1'b0;
        end else if (push) begin
            r_mvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_mvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mdata <= res_sel;
            r_mlast <= ((r_pend & ~sel) == 3'b000);
        end
    end

    assign m_axis_tvalid = r_mvalid;
    assign m_axis_tdata  = {r_mdata.value, r_mdata.col, r_mdata.row};
    assign m_axis_tlast  = r_mlast;

endmodule
`default_nettype wire

[design/rce_checker.sv]
// Port-level checks of the Roberts cross edge core and their binding.
`default_nettype none
`include "roberts_cross_edge_core_defines.svh"
module rce_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata,
    input wire        m_axis_tlast
);
    import rce_pkg::*;

    logic [OUT_W:0] out_word;
    assign out_word = {m_axis_tlast, m_axis_tdata};

    `RCE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(out_word))
    `RCE_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)
    `RCE_ASSERT_NOW(a_emit_after_work, $rose(m_axis_tvalid), !$past(s_axis_tready))
    `RCE_ASSERT_RST(a_reset_quiet, !i_rst_n, !m_axis_tvalid)

endmodule

bind roberts_cross_edge_core rce_checker u_rce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

[verif/rce_edge_checker.sv]
// Checker of the Roberts cross edge core: predicts results from the pixel stream and compares.
`timescale 1ns / 1ps
module rce_edge_checker #(
    parameter int MAX_WIDTH = 4096
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          s_axis_tvalid,
    input  wire                          s_axis_tready,
    input  wire  [7:0]                   s_axis_tdata,   // [7:0] pixel
    input  wire                          m_axis_tvalid,
    input  wire                          m_axis_tready,
    input  wire  [rce_pkg::OUT_W-1:0]    m_axis_tdata,   // [11:0] out_row, [23:12] out_col,
                                                         // [31:24] edge_value
    input  wire                          m_axis_tlast,   // last_of_run
    input  wire                          i_cfg_we,
    input  wire                          i_cfg_index,
    input  wire  [rce_pkg::CFG_W-1:0]    i_cfg_data,
    output int unsigned                  o_fail_count,
    output int unsigned                  o_pending
);

    localparam int PIX_W = rce_pkg::PIX_W;
    localparam int POS_W = rce_pkg::POS_W;
    localparam int CFG_W = rce_pkg::CFG_W;
    localparam int IDX_W = $clog2(MAX_WIDTH);

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] value;
        logic             last;
    } t_edge_due;

    t_edge_due                 edge_results_due[$];
    logic [PIX_W-1:0]          prev_row_store [MAX_WIDTH];
    logic [PIX_W-1:0]          left_pix;
    logic [PIX_W-1:0]          above_left_pix;
    int unsigned               next_col;
    int unsigned               next_row;
    logic [CFG_W-1:0]          width_reg;
    logic [CFG_W-1:0]          height_reg;
    int unsigned               fail_total = 0;

    initial begin
        for (int i = 0; i < MAX_WIDTH; i++) prev_row_store[i] = '0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        fail_total++;
    endtask

    function automatic int unsigned clamp_size(input int unsigned v,
                                               input int unsigned ceiling);
        if (v < 32'(rce_pkg::CFG_MIN)) return 32'(rce_pkg::CFG_MIN);
        if (v > ceiling) return ceiling;
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] root_floor_sat(input int unsigned energy);
        logic [8:0] est;
        est = '0;
        for (int b = 8; b >= 0; b--) begin
            est[b] = 1'b1;
            if (int'(est) * int'(est) > energy) est[b] = 1'b0;
        end
        return (est > 9'd255) ? 8'd255 : est[7:0];
    endfunction

    function automatic t_edge_due due_item(input logic [POS_W-1:0] row,
                                           input logic [POS_W-1:0] col,
                                           input logic [PIX_W-1:0] value);
        t_edge_due item;
        item.row   = row;
        item.col   = col;
        item.value = value;
        item.last  = 1'b0;
        return item;
    endfunction

    task automatic take_pixel(input logic [PIX_W-1:0] px);
        int unsigned      w;
        int unsigned      h;
        int unsigned      r;
        int unsigned      c;
        logic [IDX_W-1:0] idx;
        logic [PIX_W-1:0] above;
        int               d_main;
        int               d_anti;
        t_edge_due        due [3];
        int               n;
        w      = clamp_size(32'(width_reg), MAX_WIDTH);
        h      = clamp_size(32'(height_reg), 32'(rce_pkg::HEIGHT_MAX));
        r      = next_row;
        c      = next_col;
        idx    = IDX_W'(c % MAX_WIDTH);
        above  = prev_row_store[idx];
        n      = 0;
        if (r >= 1 && c >= 1) begin
            d_main = int'(above_left_pix) - int'(px);
            d_anti = int'(left_pix) - int'(above);
            due[n] = due_item(POS_W'(r - 1), POS_W'(c - 1),
                              root_floor_sat(d_main * d_main + d_anti * d_anti));
            n++;
        end
        if (r >= 1 && c == w - 1) begin
            due[n] = due_item(POS_W'(r - 1), POS_W'(c), above);
            n++;
        end
        if (r == h - 1) begin
            due[n] = due_item(POS_W'(r), POS_W'(c), px);
            n++;
        end
        if (n > 0) due[n-1].last = 1'b1;
        for (int k = 0; k < n; k++) edge_results_due.push_back(due[k]);
        above_left_pix = above;
        left_pix       = px;
        prev_row_store[idx] = px;
        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end
    endtask

    task automatic match_result();
        t_edge_due        want;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] value;
        row   = m_axis_tdata[POS_W-1:0];
        col   = m_axis_tdata[2*POS_W-1:POS_W];
        value = m_axis_tdata[rce_pkg::OUT_W-1:2*POS_W];
        if (edge_results_due.size() == 0) begin
            report_mismatch($sformatf("result row %0d col %0d with nothing due", row, col));
        end else begin
            want = edge_results_due.pop_front();
            if (row != want.row)
                report_mismatch($sformatf("out_row %0d, want %0d", row, want.row));
            if (col != want.col)
                report_mismatch($sformatf("out_col %0d, want %0d", col, want.col));
            if (value != want.value)
                report_mismatch($sformatf("edge_value %0d, want %0d at row %0d col %0d",
                                          value, want.value, want.row, want.col));
            if (m_axis_tlast != want.last)
                report_mismatch($sformatf("tlast %0b, want %0b at row %0d col %0d",
                                          m_axis_tlast, want.last, want.row, want.col));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            width_reg      = CFG_W'(rce_pkg::WIDTH_RST);
            height_reg     = CFG_W'(32'(rce_pkg::HLAST_RST) + 1);
            next_col       = 0;
            next_row       = 0;
            left_pix       = '0;
            above_left_pix = '0;
            edge_results_due.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) match_result();
            if (i_cfg_we) begin
                if (i_cfg_index == rce_pkg::REG_WIDTH) width_reg = i_cfg_data;
                else height_reg = i_cfg_data;
                next_col = 0;
                next_row = 0;
            end
            if (s_axis_tvalid && s_axis_tready) take_pixel(s_axis_tdata);
        end
        o_pending    <= edge_results_due.size();
        o_fail_count <= fail_total;
    end

endmodule

[verif/tb_roberts_cross_edge_core.sv]
// Testbench top of the Roberts cross edge core: drives pixels, frame sizes and stalls.
`timescale 1ns / 1ps
module tb_roberts_cross_edge_core;

    localparam int MAX_WIDTH    = 4096;
    localparam int CFG_W        = rce_pkg::CFG_W;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 24;

    logic                        i_clk         = 1'b0;
    logic                        i_rst_n       = 1'b0;
    logic                        s_axis_tvalid = 1'b0;
    logic [7:0]                  s_axis_tdata  = '0;
    logic                        m_axis_tready = 1'b0;
    logic                        i_cfg_we      = 1'b0;
    logic                        i_cfg_index   = rce_pkg::REG_WIDTH;
    logic [rce_pkg::CFG_W-1:0]   i_cfg_data    = '0;
    wire                         s_axis_tready;
    wire                         m_axis_tvalid;
    wire  [rce_pkg::OUT_W-1:0]   m_axis_tdata;
    wire                         m_axis_tlast;

    int unsigned send_idle_pct = 15;
    int unsigned recv_idle_pct = 54;
    int unsigned cycle_count   = 0;
    int unsigned fail_count;
    int unsigned pending_count;

    roberts_cross_edge_core #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    rce_edge_checker #(
        .MAX_WIDTH(MAX_WIDTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_pixel(input logic [7:0] px);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // hold the stream until every result is out, then let an unproductive pixel finish
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic index, input logic [rce_pkg::CFG_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic resize(input int unsigned w, input int unsigned h);
        settle();
        write_reg(rce_pkg::REG_WIDTH, CFG_W'(w));
        write_reg(rce_pkg::REG_HEIGHT, CFG_W'(h));
    endtask

    function automatic logic [7:0] random_pixel();
        int unsigned pick;
        pick = $urandom_range(4);
        if (pick == 0) return 8'h00;
        if (pick == 1) return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    task automatic run_phase(input int unsigned send_pct, input int unsigned recv_pct,
                             input int unsigned target);
        int unsigned sent;
        int unsigned frame_w;
        int unsigned frame_h;
        int unsigned count;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent          = 0;
        frame_w       = $urandom_range(2, 10);
        frame_h       = $urandom_range(2, 6);
        resize(frame_w, frame_h);
        while (sent < target) begin
            if ($urandom_range(9) < 7) count = frame_w * frame_h * $urandom_range(1, 2);
            else count = $urandom_range(1, 2 * frame_w * frame_h);
            repeat (count) send_pixel(random_pixel());
            sent += count;
            frame_h = $urandom_range(2, 6);
            if ($urandom_range(3) == 0) begin
                settle();
                write_reg(rce_pkg::REG_HEIGHT, CFG_W'(frame_h));
            end else begin
                frame_w = $urandom_range(2, 10);
                resize(frame_w, frame_h);
            end
        end
    endtask

    initial begin
        logic [7:0] tiny_frames [12] = '{8'd0, 8'd0, 8'd255, 8'd255,
                                         8'd255, 8'd255, 8'd0, 8'd0,
                                         8'd0, 8'd255, 8'd255, 8'd0};
        logic [7:0] narrow_rows [9]  = '{8'd0, 8'd255, 8'd1,
                                         8'd254, 8'd128, 8'd127,
                                         8'd255, 8'd0, 8'd64};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sizes below the minimum clamp to a 2x2 frame; diagonals of 255 saturate
        resize(0, 1);
        foreach (tiny_frames[i]) send_pixel(tiny_frames[i]);
        resize(3, 8191);
        foreach (narrow_rows[i]) send_pixel(narrow_rows[i]);
        resize(4096, 4096);
        repeat (3) send_pixel(random_pixel());

        run_phase(15, 54, 20);
        run_phase(54, 15, 20);
        run_phase(0, 0, 20);

        settle();

        if (fail_count == 0 && pending_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/rce_pkg.sv
design/roberts_cross_edge_core.sv
design/rce_checker.sv
verif/rce_edge_checker.sv
verif/tb_roberts_cross_edge_core.sv
